/* hdl/dts_pkg.sv */
// ----------------------------------------------------------------------------
// dts_pkg - shared definitions for the date to seconds converter
// Field widths, stream packing and the calendar constants and tables.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  // Field widths
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned ELAPSED_W = 32;

  // Stream packing, first field in the lowest bits
  localparam int unsigned IN_BITS   = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
  localparam int unsigned S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((ELAPSED_W + 7) / 8) * 8;

  localparam int unsigned YEAR_LSB   = 0;
  localparam int unsigned MONTH_LSB  = YEAR_LSB + YEAR_W;
  localparam int unsigned DAY_LSB    = MONTH_LSB + MONTH_W;
  localparam int unsigned HOUR_LSB   = DAY_LSB + DAY_W;
  localparam int unsigned MINUTE_LSB = HOUR_LSB + HOUR_W;
  localparam int unsigned SECOND_LSB = MINUTE_LSB + MINUTE_W;

  // Reset value of the reference year register
  localparam logic [YEAR_W-1:0] REF_YEAR_RESET = YEAR_W'(1990);

  // Division by 100 of a year-wide value: (x * DIV100_MUL) >> DIV100_SHIFT,
  // exact for every 12-bit x
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_PW    = YEAR_W + 13;
  localparam int unsigned QUOT_W       = DIV100_PW - DIV100_SHIFT;

  // Leap-year counts and day counts
  localparam int unsigned LEAPS_W   = 11;
  localparam int unsigned DBM_W     = 9;
  localparam int unsigned TOD_W     = 17;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned SECS_PER_DAY  = 24 * 60 * 60;
  localparam int unsigned SECS_PER_HOUR = 60 * 60;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);

  // Days before the first of a month in a common year; codes past December
  // count the whole year
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [DBM_W-1:0] d;
    unique case (month)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/date_to_seconds_converter.sv */
// ----------------------------------------------------------------------------
// date_to_seconds_converter - calendar date and time to elapsed seconds
// Four-stage pipeline turning a Gregorian date and time of day into the
// seconds elapsed since 1 January 00:00:00 of a programmable reference year.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis_*): one date per transfer, fields packed in tdata.
//   Master stream (m_axis_*): one 32-bit elapsed-seconds count per date, in
//   the order the dates came in.
//   Config channel (cfg_*): writes the reference year; always ready. Write
//   it only while no date is in flight.
// Pipeline: a date passes the stage 1 to stage 4 registers on its way to
//   m_axis_tvalid. Throughput: one date per cycle while the receiver is
//   ready; the long path is the day count times 86400 in the last stage.
// Reset: rst_ni clears all stage valid bits and loads the reference year
//   with 1990. Nothing comes out until a date is sent.
// Stall: each stage holds while the stage after it is full and not moving,
//   so empty stages keep filling while the receiver holds m_axis_tready low;
//   s_axis_tready drops only when all four stages are full.
// Years before the reference year add no whole-year term. Fields are not
// range-checked and the result wraps modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module date_to_seconds_converter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Slave stream. tdata: year[11:0], month[15:12], day[20:16], hour[25:21],
  // minute[31:26], second[37:32], zero fill[39:38]
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [dts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // Master stream. tdata: elapsed_seconds[31:0]
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [dts_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // Reference year write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dts_pkg::YEAR_W-1:0]     cfg_data_i
);

  localparam int unsigned YW = dts_pkg::YEAR_W;
  localparam int unsigned QW = dts_pkg::QUOT_W;
  localparam int unsigned PW = dts_pkg::DIV100_PW;
  localparam int unsigned LW = dts_pkg::LEAPS_W;
  localparam int unsigned EW = dts_pkg::ELAPSED_W;

  // --------------------------------------------------------------------------
  // Reference year register
  // --------------------------------------------------------------------------
  logic [YW-1:0] ref_year_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_year_q <= dts_pkg::REF_YEAR_RESET;
    end else if (cfg_valid_i) begin
      ref_year_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  assign s4_rdy = !s4_v_q || m_axis_tready;
  assign s3_rdy = !s3_v_q || s4_rdy;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign s_axis_tready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= s_axis_tvalid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (s4_rdy) s4_v_q <= s3_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpack, divide the years by 100 with a reciprocal multiply
  // --------------------------------------------------------------------------
  logic [YW-1:0]                in_year;
  logic [dts_pkg::MONTH_W-1:0]  in_month;
  logic [dts_pkg::DAY_W-1:0]    in_day;
  logic [dts_pkg::HOUR_W-1:0]   in_hour;
  logic [dts_pkg::MINUTE_W-1:0] in_minute;
  logic [dts_pkg::SECOND_W-1:0] in_second;
  logic [PW-1:0]                prod_py, prod_y, prod_pr;

  assign in_year   = s_axis_tdata[dts_pkg::YEAR_LSB   +: YW];
  assign in_month  = s_axis_tdata[dts_pkg::MONTH_LSB  +: dts_pkg::MONTH_W];
  assign in_day    = s_axis_tdata[dts_pkg::DAY_LSB    +: dts_pkg::DAY_W];
  assign in_hour   = s_axis_tdata[dts_pkg::HOUR_LSB   +: dts_pkg::HOUR_W];
  assign in_minute = s_axis_tdata[dts_pkg::MINUTE_LSB +: dts_pkg::MINUTE_W];
  assign in_second = s_axis_tdata[dts_pkg::SECOND_LSB +: dts_pkg::SECOND_W];

  // (year - 1) / 100, year / 100 and (reference - 1) / 100
  assign prod_py = PW'(in_year - YW'(1)) * PW'(dts_pkg::DIV100_MUL);
  assign prod_y  = PW'(in_year) * PW'(dts_pkg::DIV100_MUL);
  assign prod_pr = PW'(ref_year_q - YW'(1)) * PW'(dts_pkg::DIV100_MUL);

  logic [YW-1:0]                s1_year_q, s1_ref_q;
  logic [QW-1:0]                s1_qpy_q, s1_qy_q, s1_qpr_q;
  logic [dts_pkg::MONTH_W-1:0]  s1_month_q;
  logic [dts_pkg::DAY_W-1:0]    s1_day_q;
  logic [dts_pkg::HOUR_W-1:0]   s1_hour_q;
  logic [dts_pkg::MINUTE_W-1:0] s1_minute_q;
  logic [dts_pkg::SECOND_W-1:0] s1_second_q;

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_year_q   <= in_year;
      s1_ref_q    <= ref_year_q;
      s1_qpy_q    <= prod_py[PW-1:dts_pkg::DIV100_SHIFT];
      s1_qy_q     <= prod_y[PW-1:dts_pkg::DIV100_SHIFT];
      s1_qpr_q    <= prod_pr[PW-1:dts_pkg::DIV100_SHIFT];
      s1_month_q  <= in_month;
      s1_day_q    <= in_day;
      s1_hour_q   <= in_hour;
      s1_minute_q <= in_minute;
      s1_second_q <= in_second;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: leap-year counts below each year, leap flag, month offset and
  // time of day in seconds
  // --------------------------------------------------------------------------
  logic [YW-1:0]             py, pr;
  logic [LW-1:0]             leaps_y, leaps_r;
  logic [YW:0]               hundreds_y;
  logic                      is_leap;
  logic [dts_pkg::DBM_W-1:0] dbm;
  logic [dts_pkg::TOD_W-1:0] tod;

  assign py = s1_year_q - YW'(1);
  assign pr = s1_ref_q - YW'(1);

  // Leaps in [0, y) = (y-1)/4 - (y-1)/100 + (y-1)/400 + 1, none below year zero
  assign leaps_y = (s1_year_q == '0) ? '0 :
                   LW'(py[YW-1:2]) - LW'(s1_qpy_q) + LW'(s1_qpy_q[QW-1:2]) + LW'(1);
  assign leaps_r = (s1_ref_q == '0) ? '0 :
                   LW'(pr[YW-1:2]) - LW'(s1_qpr_q) + LW'(s1_qpr_q[QW-1:2]) + LW'(1);

  // Century years are leap only when the century count is a multiple of 4
  assign hundreds_y = (YW+1)'(s1_qy_q) * (YW+1)'(100);
  assign is_leap    = (s1_year_q[1:0] == 2'b00) &&
                      ((hundreds_y != {1'b0, s1_year_q}) || (s1_qy_q[1:0] == 2'b00));

  assign dbm = dts_pkg::days_before_month(s1_month_q) +
               dts_pkg::DBM_W'(is_leap && (s1_month_q > dts_pkg::FEBRUARY));

  assign tod = dts_pkg::TOD_W'(s1_hour_q) * dts_pkg::TOD_W'(dts_pkg::SECS_PER_HOUR) +
               dts_pkg::TOD_W'(s1_minute_q) * dts_pkg::TOD_W'(dts_pkg::SECS_PER_MIN) +
               dts_pkg::TOD_W'(s1_second_q);

  logic                      s2_after_q;
  logic [YW-1:0]             s2_diff_q;
  logic [LW-1:0]             s2_leaps_y_q, s2_leaps_r_q;
  logic [dts_pkg::DBM_W-1:0] s2_dbm_q;
  logic [dts_pkg::DAY_W-1:0] s2_day_q;
  logic [dts_pkg::TOD_W-1:0] s2_tod_q;

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_after_q   <= s1_year_q > s1_ref_q;
      s2_diff_q    <= s1_year_q - s1_ref_q;
      s2_leaps_y_q <= leaps_y;
      s2_leaps_r_q <= leaps_r;
      s2_dbm_q     <= dbm;
      s2_day_q     <= s1_day_q;
      s2_tod_q     <= tod;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: total day count; day of month counts from 1, day zero wraps
  // --------------------------------------------------------------------------
  logic [EW-1:0] year_days, days;

  assign year_days = s2_after_q ?
                     (EW'(s2_diff_q) * EW'(dts_pkg::DAYS_PER_YEAR) +
                      EW'(s2_leaps_y_q) - EW'(s2_leaps_r_q)) : '0;
  assign days      = year_days + EW'(s2_dbm_q) + EW'(s2_day_q) - EW'(1);

  logic [EW-1:0]             s3_days_q;
  logic [dts_pkg::TOD_W-1:0] s3_tod_q;

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_days_q <= days;
      s3_tod_q  <= s2_tod_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: scale days to seconds and add the time of day, modulo 2^32
  // --------------------------------------------------------------------------
  logic [EW-1:0] s4_total_q;

  always_ff @(posedge clk_i) begin
    if (s4_rdy) begin
      s4_total_q <= s3_days_q * EW'(dts_pkg::SECS_PER_DAY) + EW'(s3_tod_q);
    end
  end

  assign m_axis_tvalid = s4_v_q;
  assign m_axis_tdata  = dts_pkg::M_TDATA_W'(s4_total_q);

endmodule

`default_nettype wire

/* hdl/dts_checker.sv */
// ----------------------------------------------------------------------------
// dts_checker - port-level checks for the date to seconds converter
// Watches the stream and config ports; bound onto the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [dts_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // A ready receiver never backs up the input side
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  // With the receiver ready, a transfer passes every stage register to m_axis_tvalid
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing four cycles after transfer");

  // Reset leaves the output side empty
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // The reference year write channel never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind date_to_seconds_converter dts_checker u_dts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

/* test/date_to_seconds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_to_seconds_checker - scoreboard for the date to seconds converter
// Watches the date, result and reference year channels, works out the
// elapsed seconds of each accepted date and compares results in order.
// ----------------------------------------------------------------------------

module date_to_seconds_checker
  import dts_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  input  wire logic                 s_tready_i,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  input  wire logic                 m_tvalid_i,
  input  wire logic                 m_tready_i,
  input  wire logic [M_TDATA_W-1:0] m_tdata_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [YEAR_W-1:0]    cfg_data_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               pending_o
);

  localparam longint unsigned DAY_SECS  = 86400;
  localparam longint unsigned HOUR_SECS = 3600;
  localparam longint unsigned MIN_SECS  = 60;
  localparam int unsigned     MAX_PRINT = 100;

  logic [YEAR_W-1:0]    epoch_year;
  logic [ELAPSED_W-1:0] expected_seconds_q[$];

  function automatic bit is_leap_year(input logic [YEAR_W-1:0] y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400 == 0);
  endfunction

  // Leap years in [0, y); year zero counts as leap
  function automatic longint unsigned leap_years_below(input logic [YEAR_W-1:0] y);
    longint unsigned p;
    if (y == 0) return 0;
    p = y - 1;
    return p / 4 - p / 100 + p / 400 + 1;
  endfunction

  function automatic longint unsigned month_length(input int unsigned m);
    case (m)
      2:             return 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] seconds_since_epoch(
    input logic [YEAR_W-1:0]   base_year,
    input logic [S_TDATA_W-1:0] date
  );
    logic [YEAR_W-1:0]   yr;
    logic [MONTH_W-1:0]  mo;
    logic [DAY_W-1:0]    dy;
    logic [HOUR_W-1:0]   hr;
    logic [MINUTE_W-1:0] mi;
    logic [SECOND_W-1:0] sc;
    longint unsigned     days;
    longint unsigned     total;
    yr = date[YEAR_LSB +: YEAR_W];
    mo = date[MONTH_LSB +: MONTH_W];
    dy = date[DAY_LSB +: DAY_W];
    hr = date[HOUR_LSB +: HOUR_W];
    mi = date[MINUTE_LSB +: MINUTE_W];
    sc = date[SECOND_LSB +: SECOND_W];
    days = 0;
    // whole years count only after the epoch year
    if (yr > base_year)
      days = 365 * longint'(yr - base_year) + leap_years_below(yr)
             - leap_years_below(base_year);
    // whole months, capped at a full year for codes past December
    for (int unsigned m = 1; m < mo && m <= 12; m++) days += month_length(m);
    if (mo > 2 && is_leap_year(yr)) days += 1;
    // day counts from one; day zero wraps below zero
    total = days * DAY_SECS + longint'(dy) * DAY_SECS - DAY_SECS
            + longint'(hr) * HOUR_SECS + longint'(mi) * MIN_SECS + longint'(sc);
    return total[ELAPSED_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count_o < MAX_PRINT) $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ELAPSED_W-1:0] want;
    if (!rst_ni) begin
      epoch_year = REF_YEAR_RESET;
      expected_seconds_q.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        expected_seconds_q.push_back(seconds_since_epoch(epoch_year, s_tdata_i));
      if (cfg_valid_i && cfg_ready_i) epoch_year = cfg_data_i;
      if (m_tvalid_i && m_tready_i) begin
        if (expected_seconds_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no date outstanding",
                                    m_tdata_i[ELAPSED_W-1:0]));
        end else begin
          want = expected_seconds_q.pop_front();
          if (m_tdata_i[ELAPSED_W-1:0] !== want)
            report_mismatch($sformatf("elapsed_seconds got %0d, want %0d",
                                      m_tdata_i[ELAPSED_W-1:0], want));
        end
      end
      pending_o = expected_seconds_q.size();
    end
  end

endmodule

/* test/tb_date_to_seconds_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_to_seconds_converter - stimulus and verdict for the converter
// Drives directed corner dates and bursts of random dates under several
// reference years, with random gaps on the sender, random stalls on the
// receiver and long receiver hold-offs; a checker scores every result.
// ----------------------------------------------------------------------------

module tb_date_to_seconds_converter;
  import dts_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 270;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned PRESSURE_ITEMS  = 30;
  localparam int unsigned SETTLE_CYCLES   = 10;
  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned NUM_RETARGETS   = 6;

  // Receiver readiness patterns
  typedef enum int unsigned {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_DENSE
  } rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // tdata: year, month, day, hour, minute, second, zero fill (lowest first)
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // tdata: elapsed_seconds
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [YEAR_W-1:0]    cfg_data_i;

  int unsigned          mismatch_count;
  int unsigned          pending_count;
  int unsigned          cycle_count;
  bit                   hold_off_req;
  logic [YEAR_W-1:0]    epoch_year_now;

  date_to_seconds_converter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  date_to_seconds_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run: the slowest legal run stays far below this bound
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Pack one date; the zero fill above the last field stays low
  function automatic logic [S_TDATA_W-1:0] pack_date(
    input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo,
    input logic [DAY_W-1:0] dy, input logic [HOUR_W-1:0] hr,
    input logic [MINUTE_W-1:0] mi, input logic [SECOND_W-1:0] sc
  );
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[YEAR_LSB +: YEAR_W]     = yr;
    d[MONTH_LSB +: MONTH_W]   = mo;
    d[DAY_LSB +: DAY_W]       = dy;
    d[HOUR_LSB +: HOUR_W]     = hr;
    d[MINUTE_LSB +: MINUTE_W] = mi;
    d[SECOND_LSB +: SECOND_W] = sc;
    return d;
  endfunction

  // Mostly calendar-valid dates, some close to the epoch year so both sides
  // of it show up, and a share of raw field values over the full widths
  function automatic logic [S_TDATA_W-1:0] random_date();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)
      return pack_date(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                       HOUR_W'($urandom), MINUTE_W'($urandom), SECOND_W'($urandom));
    return pack_date(
      (pick < 35) ? YEAR_W'(epoch_year_now + $urandom_range(0, 4) - 2)
                  : YEAR_W'($urandom_range(1970, 2099)),
      MONTH_W'($urandom_range(1, 12)), DAY_W'($urandom_range(1, 31)),
      HOUR_W'($urandom_range(0, 23)), MINUTE_W'($urandom_range(0, 59)),
      SECOND_W'($urandom_range(0, 59)));
  endfunction

  // Offer one date and hold it until the transfer; valid stays high after
  task automatic send_date(input logic [S_TDATA_W-1:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid for a gap; the idle bus carries junk the block must ignore
  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_TDATA_W'({$urandom, $urandom});
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_random_bursts(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_date(random_date());
      left -= burst;
      // a third of the bursts run straight into the next one
      idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
    end
  endtask

  // Ask the receiver for a long hold-off and keep the input busy meanwhile,
  // so every stage fills and the block has to push back on the sender
  task automatic send_under_pressure();
    hold_off_req = 1'b1;
    repeat (PRESSURE_ITEMS) send_date(random_date());
  endtask

  // Wait until every accepted date has produced its result
  task automatic drain();
    idle_gap(1);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic write_epoch_year(input logic [YEAR_W-1:0] yr);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= yr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    epoch_year_now = yr;
  endtask

  task automatic send_directed(
    input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo,
    input logic [DAY_W-1:0] dy, input logic [HOUR_W-1:0] hr,
    input logic [MINUTE_W-1:0] mi, input logic [SECOND_W-1:0] sc
  );
    send_date(pack_date(yr, mo, dy, hr, mi, sc));
    idle_gap($urandom_range(0, 2));
  endtask

  // Receiver: stretches of random readiness patterns, full-rate stretches
  // among them, plus the long hold-off whenever the sender asks for one
  initial begin
    int unsigned stretch;
    rx_mode_e    mode;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stretch = $urandom_range(1, 40);
        mode    = rx_mode_e'($urandom_range(0, 3));
        repeat (stretch) begin
          case (mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [YEAR_W-1:0] retarget[NUM_RETARGETS];
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    hold_off_req   = 1'b0;
    epoch_year_now = REF_YEAR_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner dates against the reset epoch year
    send_directed(12'd1990, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);       // second zero
    send_directed(12'd1989, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);  // just before
    send_directed(12'd1991, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_directed(12'd1970, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30);   // before epoch
    send_directed(12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_directed(12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);       // 400-year leap
    send_directed(12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);       // plain century
    send_directed(12'd1900, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_directed(12'd1996, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);     // leap day
    send_directed(12'd1996, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_directed(12'd2004, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
    send_directed(12'd1995, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3);      // month zero
    send_directed(12'd1995, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0);      // past December
    send_directed(12'd1996, 4'd15, 5'd2, 5'd0, 6'd0, 6'd1);
    send_directed(12'd1990, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0);       // day zero wraps
    send_directed(12'd1992, 4'd7, 5'd31, 5'd0, 6'd0, 6'd0);
    send_directed(12'd1993, 4'd5, 5'd9, 5'd31, 6'd63, 6'd63);    // time overrange
    send_directed(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);          // all low
    send_directed(12'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);          // year zero leap
    send_directed(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);  // all high
    send_random_bursts(ITEMS_PER_PHASE);

    // Retarget the epoch: both range ends, the field extremes, random picks
    retarget[0] = 12'd1970;
    retarget[1] = 12'd2099;
    retarget[2] = 12'd0;
    retarget[3] = 12'd4095;
    retarget[4] = YEAR_W'($urandom_range(1970, 2099));
    retarget[5] = YEAR_W'($urandom);
    for (int i = 0; i < NUM_RETARGETS; i++) begin
      drain();
      write_epoch_year(retarget[i]);
      if (i == 0 || i == 4) send_under_pressure();
      send_random_bursts(ITEMS_PER_PHASE);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dts_pkg.sv
hdl/date_to_seconds_converter.sv
hdl/dts_checker.sv
test/date_to_seconds_checker.sv
test/tb_date_to_seconds_converter.sv
